// ----- sv/i2r_pkg.sv -----
// ----------------------------------------------------------------------------
// i2r_pkg: Roman numeral encoder definitions
// Greedy numeral table: each entry has a weight, a leading symbol and,
// for subtractive pairs, a second symbol.
// ----------------------------------------------------------------------------
package i2r_pkg;

	localparam int ValueW = 12;
	localparam int SymW   = 8;
	localparam int IdxW   = 4;

	localparam logic [ValueW-1:0] MaxValid = ValueW'(3999);

	localparam logic [SymW-1:0] SymNone = 8'h00;
	localparam logic [SymW-1:0] SymM    = 8'h4D;
	localparam logic [SymW-1:0] SymD    = 8'h44;
	localparam logic [SymW-1:0] SymC    = 8'h43;
	localparam logic [SymW-1:0] SymL    = 8'h4C;
	localparam logic [SymW-1:0] SymX    = 8'h58;
	localparam logic [SymW-1:0] SymV    = 8'h56;
	localparam logic [SymW-1:0] SymI    = 8'h49;

	typedef struct packed {
		logic [ValueW-1:0] weight;
		logic [SymW-1:0]   sym_a;
		logic [SymW-1:0]   sym_b;
		logic              pair;
	} entry_t;

	// Entries ordered from the largest weight down; the last entry is one.
	function automatic entry_t table_entry(input logic [IdxW-1:0] idx);
		entry_t e;
		e = '{weight: ValueW'(1), sym_a: SymI, sym_b: SymNone, pair: 1'b0};
		unique case (idx)
			4'd0:  e = '{weight: ValueW'(1000), sym_a: SymM, sym_b: SymNone, pair: 1'b0};
			4'd1:  e = '{weight: ValueW'(900),  sym_a: SymC, sym_b: SymM,    pair: 1'b1};
			4'd2:  e = '{weight: ValueW'(500),  sym_a: SymD, sym_b: SymNone, pair: 1'b0};
			4'd3:  e = '{weight: ValueW'(400),  sym_a: SymC, sym_b: SymD,    pair: 1'b1};
			4'd4:  e = '{weight: ValueW'(100),  sym_a: SymC, sym_b: SymNone, pair: 1'b0};
			4'd5:  e = '{weight: ValueW'(90),   sym_a: SymX, sym_b: SymC,    pair: 1'b1};
			4'd6:  e = '{weight: ValueW'(50),   sym_a: SymL, sym_b: SymNone, pair: 1'b0};
			4'd7:  e = '{weight: ValueW'(40),   sym_a: SymX, sym_b: SymL,    pair: 1'b1};
			4'd8:  e = '{weight: ValueW'(10),   sym_a: SymX, sym_b: SymNone, pair: 1'b0};
			4'd9:  e = '{weight: ValueW'(9),    sym_a: SymI, sym_b: SymX,    pair: 1'b1};
			4'd10: e = '{weight: ValueW'(5),    sym_a: SymV, sym_b: SymNone, pair: 1'b0};
			4'd11: e = '{weight: ValueW'(4),    sym_a: SymI, sym_b: SymV,    pair: 1'b1};
			default: e = '{weight: ValueW'(1),  sym_a: SymI, sym_b: SymNone, pair: 1'b0};
		endcase
		return e;
	endfunction

endpackage

// ----- sv/integer_to_roman_encoder.sv -----
// ----------------------------------------------------------------------------
// integer_to_roman_encoder: value to Roman numeral character stream
// Converts a 12-bit value into ASCII numeral characters, one per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, value) takes one value per request.
//   in_stall is high while a value is being encoded; the next value is taken
//   once the last character of the current one is in the output register.
//   Output channel (out_valid/out_stall, symbol/last/invalid) gives one
//   character per request, most significant symbol first, last set on the
//   final character. A value of 0 or above 3999 gives a single request with
//   symbol 0, last 1 and invalid 1.
//   Structure: one shared compare/subtract unit walks a 13-entry numeral table.
//   Each step it either emits one character or moves to the next entry, so
//   a value gives n characters and skips k entries (k <= 12).
//   While out_stall is high and the output register is full the sequencer
//   emits nothing, though it may still move to the next entry. Reset clears
//   the sequencer and empties the output register.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder
	import i2r_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ValueW-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SymW-1:0]   symbol,
	output logic              last,
	output logic              invalid
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_BAD} state_t;

	state_t            state_q;
	logic [ValueW-1:0] rem_q;
	logic [IdxW-1:0]   idx_q;
	logic              second_q;
	logic              out_valid_q;
	logic [SymW-1:0]   symbol_q;
	logic              last_q;
	logic              invalid_q;

	entry_t          ent;
	logic [ValueW:0] diff;
	logic            ge;
	logic            slot;
	logic            emit;

	// Shared compare/subtract unit against the current table entry.
	always_comb begin
		ent  = table_entry(idx_q);
		diff = {1'b0, rem_q} - {1'b0, ent.weight};
		ge   = ~diff[ValueW];
		slot = ~out_valid_q | ~out_stall;
		emit = slot & ((state_q == ST_BAD) |
			((state_q == ST_RUN) & (second_q | ge)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			idx_q       <= '0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
			symbol_q    <= SymNone;
			last_q      <= 1'b0;
			invalid_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rem_q    <= value;
						idx_q    <= '0;
						second_q <= 1'b0;
						if (value == '0 || value > MaxValid) begin
							state_q <= ST_BAD;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_BAD: begin
					if (slot) begin
						symbol_q    <= SymNone;
						last_q      <= 1'b1;
						invalid_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (second_q) begin
						// finish a subtractive pair; remainder already reduced
						if (slot) begin
							symbol_q    <= ent.sym_b;
							last_q      <= (rem_q == '0);
							invalid_q   <= 1'b0;
							second_q    <= 1'b0;
							if (rem_q == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end else if (ge) begin
						if (slot) begin
							symbol_q    <= ent.sym_a;
							last_q      <= ~ent.pair & (diff[ValueW-1:0] == '0);
							invalid_q   <= 1'b0;
							rem_q       <= diff[ValueW-1:0];
							if (ent.pair) begin
								second_q <= 1'b1;
							end else if (diff[ValueW-1:0] == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						// advance to the next smaller weight
						idx_q <= idx_q + IdxW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;
	assign invalid   = invalid_q;

endmodule

// ----- tb/tb_integer_to_roman_encoder.sv -----
// ----------------------------------------------------------------------------
// tb_integer_to_roman_encoder: self-checking bench for the numeral encoder
// Sends 12-bit values through the valid/stall input channel and checks every
// character request on the output channel, symbol by symbol, against a
// digit-by-digit numeral predictor. Covers invalid values, range extremes,
// the subtractive and five-symbol forms, random values with random idling on
// both sides, and a long output hold that fills the block.
// ----------------------------------------------------------------------------
module tb_integer_to_roman_encoder;
	import i2r_pkg::*;

	localparam int IdleLimit   = 2000;
	localparam int DrainCycles = 40;
	localparam int HoldCycles  = 300;
	localparam int RandomItems = 370;
	localparam int ChunkItems  = 37;
	localparam int BurstItems  = 20;
	localparam int ReportMax   = 10;

	typedef struct packed {
		logic [SymW-1:0] symbol;
		logic            last;
		logic            invalid;
	} numeral_char_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [ValueW-1:0] value;
	logic              out_valid;
	logic              out_stall;
	logic [SymW-1:0]   symbol;
	logic              last;
	logic              invalid;

	numeral_char_t   expected_chars[$];
	logic [SymW-1:0] run_syms[$];
	int unsigned     mismatches = 0;
	int unsigned     hold_len = 0;
	bit              idle_on = 1'b0;

	integer_to_roman_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.last      (last),
		.invalid   (invalid)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= ReportMax)
			$display("%s", msg);
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic void push_digit(input int d, input logic [SymW-1:0] one,
			input logic [SymW-1:0] five, input logic [SymW-1:0] ten);
		if (d == 9) begin
			run_syms.push_back(one);
			run_syms.push_back(ten);
		end else if (d >= 5) begin
			run_syms.push_back(five);
			for (int k = 5; k < d; k++)
				run_syms.push_back(one);
		end else if (d == 4) begin
			run_syms.push_back(one);
			run_syms.push_back(five);
		end else begin
			for (int k = 0; k < d; k++)
				run_syms.push_back(one);
		end
	endfunction

	function automatic void predict_numeral(input logic [ValueW-1:0] v);
		int n;
		int cnt;
		n = int'(v);
		run_syms.delete();
		if (n == 0 || v > MaxValid) begin
			expected_chars.push_back('{symbol: SymNone, last: 1'b1, invalid: 1'b1});
			return;
		end
		for (int k = 0; k < n / 1000; k++)
			run_syms.push_back(SymM);
		push_digit((n / 100) % 10, SymC, SymD, SymM);
		push_digit((n / 10) % 10, SymX, SymL, SymC);
		push_digit(n % 10, SymI, SymV, SymX);
		cnt = run_syms.size();
		for (int i = 0; i < cnt; i++)
			expected_chars.push_back('{symbol: run_syms[i], last: (i == cnt - 1),
				invalid: 1'b0});
	endfunction

	// Offer one value, hold it until accepted, then idle for a random gap if idling is on.
	task automatic send_value(input logic [ValueW-1:0] v);
		int gap;
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_numeral(v);
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			value    <= ValueW'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [ValueW-1:0] random_value();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			if ($urandom_range(0, 1) == 0)
				return '0;
			return ValueW'($urandom_range(4000, 4095));
		end else if (r < 45) begin
			// Build from digits so long numerals show up often.
			n = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
				$urandom_range(0, 9) * 10 + $urandom_range(0, 9);
			if (n == 0)
				n = 1;
			return ValueW'(n);
		end
		return ValueW'($urandom_range(1, 3999));
	endfunction

	task automatic test_invalid_values();
		send_value(ValueW'(0));
		send_value(ValueW'(4000));
		send_value(ValueW'(4095));
	endtask

	task automatic test_range_extremes();
		send_value(ValueW'(1));
		send_value(ValueW'(2));
		send_value(ValueW'(3));
		send_value(ValueW'(3999));
		send_value(ValueW'(3888));
	endtask

	task automatic test_numeral_forms();
		int forms[15] = '{4, 9, 40, 90, 400, 900, 494, 5, 50, 500, 8, 80, 800,
			1000, 3000};
		foreach (forms[i])
			send_value(ValueW'(forms[i]));
	endtask

	task automatic test_random_values();
		for (int i = 0; i < RandomItems; i++) begin
			if (i % ChunkItems == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_value(random_value());
		end
	endtask

	task automatic test_output_hold();
		idle_on  = 1'b0;
		hold_len = HoldCycles;
		for (int i = 0; i < BurstItems; i++)
			send_value(random_value());
		idle_on = 1'b1;
	endtask

	// Output side: random stall bursts, plus a long hold when requested.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				stall_left = hold_len;
				hold_len   = 0;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		numeral_char_t got;
		numeral_char_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{symbol: symbol, last: last, invalid: invalid};
				if (expected_chars.size() == 0) begin
					note_mismatch($sformatf(
						"unexpected request: symbol %h last %b invalid %b",
						got.symbol, got.last, got.invalid));
				end else begin
					want = expected_chars.pop_front();
					if (got !== want)
						note_mismatch($sformatf(
							"mismatch: expected symbol %h last %b invalid %b, got symbol %h last %b invalid %b",
							want.symbol, want.last, want.invalid,
							got.symbol, got.last, got.invalid));
				end
			end
		end
	end

	// Drop the run if no request moves on either channel for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < IdleLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("** integer_to_roman_encoder: FAILED **");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_invalid_values();
		test_range_extremes();
		test_numeral_forms();
		test_random_values();
		test_output_hold();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("** integer_to_roman_encoder: PASSED **");
		else
			$display("** integer_to_roman_encoder: FAILED **");
		$finish;
	end

endmodule
